[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on nothing; expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`define ASSERT_SAME(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/trlvl_pkg.sv]
// Package of the turntable velocity loop: widths, register indexes and command types.
// Used by the controller, the datapath and the top level.
package trlvl_pkg;

    localparam int DAC_BITS = 12;
    localparam int IN_W     = 32;
    localparam int OUT_W    = ((DAC_BITS + 48 + 7) / 8) * 8;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 17;
    localparam logic signed [17:0] DAC_TOP = 18'((1 << DAC_BITS) - 1);

    localparam logic [CFG_IW-1:0] CFG_ACCEL  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GAIN   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_DBAND  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DRIVE  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CENTER = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_ENABLE = 3'd5;

    typedef enum logic [1:0] {
        MUL_STEP = 2'd0,
        MUL_TGT  = 2'd1,
        MUL_DAC  = 2'd2,
        MUL_ANG  = 2'd3
    } t_mul_op;

    typedef struct packed {
        t_mul_op mul_op;
        logic    cap_in;
        logic    cap_step;
        logic    upd_vel;
        logic    cap_dac;
        logic    upd_ang;
        logic    load_out;
    } t_cmd;

endpackage

[hw/rtl/turntable_rate_limited_velocity_loop_unit.sv]
// Top level of the turntable rate-limited velocity loop.
// Depends on trlvl_pkg, trlvl_ctrl, trlvl_dpath and assert_macros.svh.
//
// Usage:
//   The slave stream takes one control tick per transfer: heading error and
//   elapsed time. The master stream returns one result per tick: DAC code,
//   turn velocity and integrated table angle.
//   The configuration channel writes one register per transfer by index; it is
//   always ready and is meant to be used while no tick is in flight.
//   A tick passes the states step, target, update, drive, angle, accumulate and
//   output before its result reaches the master side. One 18 by 18 multiplier is
//   shared by the four products of a tick (step, target, drive and angle), so a
//   new tick is taken only once the sequencer is back in its idle state.
//   An output register holds the result, so the next tick is taken while a
//   result still waits. If the receiver stalls longer, the sequencer holds in
//   its last step until the output register frees.
//   Reset (synchronous, active low) loads the register defaults and clears the
//   velocity and the table angle.
`include "assert_macros.svh"

module turntable_rate_limited_velocity_loop_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // heading_error[15:0], elapsed_time[27:16], zero fill
    input  logic [trlvl_pkg::IN_W-1:0]           s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // dac_code, turn_velocity (16 bits), table_angle (32 bits), zero fill
    output logic [trlvl_pkg::OUT_W-1:0]          m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [trlvl_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [trlvl_pkg::CFG_DW-1:0]         i_cfg_data
);

    trlvl_pkg::t_cmd                cmd;
    logic [trlvl_pkg::DAC_BITS-1:0] dac_code;
    logic signed [15:0]             turn_velocity;
    logic signed [31:0]             table_angle;
    logic                           vel_ok;

    assign o_cfg_ready = 1'b1;

    trlvl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    trlvl_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_heading_error (signed'(s_axis_tdata[15:0])),
        .i_elapsed_time  (s_axis_tdata[27:16]),
        .o_dac_code      (dac_code),
        .o_turn_velocity (turn_velocity),
        .o_table_angle   (table_angle)
    );

    assign m_axis_tdata = trlvl_pkg::OUT_W'({table_angle, turn_velocity, dac_code});

    assign vel_ok = (turn_velocity <= 16'sd16384) && (turn_velocity >= -16'sd16384);

    `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "not busy")
    `ASSERT_SAME(a_vel_range, m_axis_tvalid, vel_ok, "velocity out of range")
    `ASSERT_SAME(a_result_from_seq, $rose(m_axis_tvalid), !$past(s_axis_tready), "no work")

endmodule

[hw/rtl/trlvl_ctrl.sv]
// Sequencer of the turntable velocity loop: steps one item through the shared multiplier.
// Depends on trlvl_pkg; drives the datapath by a command struct.
module trlvl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output trlvl_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MSTEP = 8'b0000_0010,
        S_MTGT  = 8'b0000_0100,
        S_UPD   = 8'b0000_1000,
        S_MDAC  = 8'b0001_0000,
        S_MANG  = 8'b0010_0000,
        S_ACC   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        o_cmd.mul_op = trlvl_pkg::MUL_STEP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_MSTEP;
                end
            end
            S_MSTEP: begin
                o_cmd.mul_op = trlvl_pkg::MUL_STEP;
                n_state      = S_MTGT;
            end
            S_MTGT: begin
                o_cmd.cap_step = 1'b1;
                o_cmd.mul_op   = trlvl_pkg::MUL_TGT;
                n_state        = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_vel = 1'b1;
                n_state       = S_MDAC;
            end
            S_MDAC: begin
                o_cmd.mul_op = trlvl_pkg::MUL_DAC;
                n_state      = S_MANG;
            end
            S_MANG: begin
                o_cmd.cap_dac = 1'b1;
                o_cmd.mul_op  = trlvl_pkg::MUL_ANG;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.upd_ang = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hw/rtl/trlvl_dpath.sv]
// Datapath of the turntable velocity loop: registers, shared multiplier and update logic.
// Depends on trlvl_pkg; follows the command struct from trlvl_ctrl.
module trlvl_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  trlvl_pkg::t_cmd                      i_cmd,
    input  logic                                 i_cfg_we,
    input  logic [trlvl_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [trlvl_pkg::CFG_DW-1:0]         i_cfg_data,
    input  logic signed [15:0]                   i_heading_error,
    input  logic [11:0]                          i_elapsed_time,
    output logic [trlvl_pkg::DAC_BITS-1:0]       o_dac_code,
    output logic signed [15:0]                   o_turn_velocity,
    output logic signed [31:0]                   o_table_angle
);

    logic [16:0]        r_accel;
    logic [11:0]        r_gain;
    logic [14:0]        r_dband;
    logic [11:0]        r_drive;
    logic [11:0]        r_center;
    logic               r_enable;

    logic signed [15:0] r_err;
    logic [11:0]        r_dt;
    logic [19:0]        r_step;
    logic signed [35:0] r_prod;
    logic signed [15:0] r_vel, n_vel;
    logic [31:0]        r_angle;
    logic [trlvl_pkg::DAC_BITS-1:0] r_dac, n_dac;

    logic [trlvl_pkg::DAC_BITS-1:0] r_out_dac;
    logic signed [15:0] r_out_vel;
    logic [31:0]        r_out_ang;

    logic signed [17:0] mul_a, mul_b;
    logic [29:0]        step_sum;
    logic signed [29:0] tgt;
    logic signed [21:0] v22, step22, nv_dn, nv_up, nv;
    logic signed [16:0] err17, db17;
    logic               outside;
    logic signed [27:0] dac_round;
    logic signed [13:0] dac_shift;
    logic signed [17:0] dac_sum;

    function automatic logic signed [29:0] times64(input logic signed [21:0] x);
        return signed'({{2{x[21]}}, x, 6'b0});
    endfunction

    always_comb begin
        case (i_cmd.mul_op)
            trlvl_pkg::MUL_STEP: begin
                mul_a = signed'({1'b0, r_accel});
                mul_b = signed'({6'b0, r_dt});
            end
            trlvl_pkg::MUL_TGT: begin
                mul_a = signed'({6'b0, r_gain});
                mul_b = signed'({{2{r_err[15]}}, r_err});
            end
            trlvl_pkg::MUL_DAC: begin
                mul_a = signed'({{2{r_vel[15]}}, r_vel});
                mul_b = signed'({6'b0, r_drive});
            end
            default: begin
                mul_a = signed'({{2{r_vel[15]}}, r_vel});
                mul_b = signed'({6'b0, r_dt});
            end
        endcase
    end

    assign step_sum = r_prod[29:0] + 30'd512;

    always_comb begin
        tgt     = -r_prod[29:0];
        v22     = signed'({{6{r_vel[15]}}, r_vel});
        step22  = signed'({2'b0, r_step});
        nv_dn   = v22 - step22;
        nv_up   = v22 + step22;
        err17   = signed'({r_err[15], r_err});
        db17    = signed'({2'b0, r_dband});
        outside = (err17 > db17) || (err17 < -db17);
        nv      = v22;
        if (outside) begin
            if (times64(v22) > tgt) begin
                if (times64(nv_dn) >= tgt) begin
                    nv = nv_dn;
                end
            end else if (times64(v22) < tgt) begin
                if (times64(nv_up) <= tgt) begin
                    nv = nv_up;
                end
            end
        end else if (v22 < 0) begin
            nv = (nv_up > 0) ? 22'sd0 : nv_up;
        end else if (v22 > 0) begin
            nv = (nv_dn < 0) ? 22'sd0 : nv_dn;
        end
        if (nv > 22'sd16384) begin
            n_vel = 16'sd16384;
        end else if (nv < -22'sd16384) begin
            n_vel = -16'sd16384;
        end else begin
            n_vel = nv[15:0];
        end
    end

    always_comb begin
        dac_round = r_prod[27:0] + 28'sd8192;
        dac_shift = dac_round[27:14];
        if (r_enable) begin
            dac_sum = signed'({6'b0, r_center}) + 18'(dac_shift);
        end else begin
            dac_sum = signed'({6'b0, r_center});
        end
        if (dac_sum < 0) begin
            n_dac = '0;
        end else if (dac_sum > trlvl_pkg::DAC_TOP) begin
            n_dac = trlvl_pkg::DAC_TOP[trlvl_pkg::DAC_BITS-1:0];
        end else begin
            n_dac = dac_sum[trlvl_pkg::DAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel  <= 17'd32768;
            r_gain   <= 12'd512;
            r_dband  <= 15'd357;
            r_drive  <= 12'd1019;
            r_center <= 12'd2048;
            r_enable <= 1'b1;
            r_vel    <= '0;
            r_angle  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    trlvl_pkg::CFG_ACCEL:  r_accel  <= i_cfg_data[16:0];
                    trlvl_pkg::CFG_GAIN:   r_gain   <= i_cfg_data[11:0];
                    trlvl_pkg::CFG_DBAND:  r_dband  <= i_cfg_data[14:0];
                    trlvl_pkg::CFG_DRIVE:  r_drive  <= i_cfg_data[11:0];
                    trlvl_pkg::CFG_CENTER: r_center <= i_cfg_data[11:0];
                    trlvl_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.upd_vel) begin
                r_vel <= n_vel;
            end
            if (i_cmd.upd_ang) begin
                r_angle <= r_angle + r_prod[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.cap_in) begin
            r_err <= i_heading_error;
            r_dt  <= i_elapsed_time;
        end
        if (i_cmd.cap_step) begin
            r_step <= step_sum[29:10];
        end
        if (i_cmd.cap_dac) begin
            r_dac <= n_dac;
        end
        if (i_cmd.load_out) begin
            r_out_dac <= r_dac;
            r_out_vel <= r_vel;
            r_out_ang <= r_angle;
        end
    end

    assign o_dac_code      = r_out_dac;
    assign o_turn_velocity = r_out_vel;
    assign o_table_angle   = signed'(r_out_ang);

endmodule

[dv/tb_turntable_rate_limited_velocity_loop_unit.sv]
`timescale 1ns / 1ps
// Testbench of the turntable rate-limited velocity loop: it drives ticks, register writes
// and random stalls, and checks every result against a predictor kept in a scoreboard class.
// Depends on trlvl_pkg and turntable_rate_limited_velocity_loop_unit.
module tb_turntable_rate_limited_velocity_loop_unit;
    import trlvl_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int TICKS_PER_PHASE  = 140;
    localparam int NUM_PHASES       = 8;
    localparam int HOLD_CYCLES      = 150;
    localparam int SETTLE_CYCLES    = 20;
    localparam longint DAC_MAX      = (longint'(1) << DAC_BITS) - 1;

    typedef struct packed {
        logic [DAC_BITS-1:0] dac;
        logic signed [15:0]  vel;
        logic [31:0]         angle;
    } tick_result_t;

    class tick_scoreboard;
        logic [16:0]        accel;
        logic [11:0]        gain;
        logic [14:0]        band;
        logic [11:0]        drive;
        logic [11:0]        center;
        logic               enable;
        logic signed [15:0] vel;
        logic [31:0]        angle;
        tick_result_t       expected_q[$];
        int fail_count, checked, slewing, in_band, held, saturated, drive_off;

        function new();
            accel = 17'd32768;
            gain = 12'd512;
            band = 15'd357;
            drive = 12'd1019;
            center = 12'd2048;
            enable = 1'b1;
            vel = '0;
            angle = '0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_ACCEL:  accel = data;
                CFG_GAIN:   gain = data[11:0];
                CFG_DBAND:  band = data[14:0];
                CFG_DRIVE:  drive = data[11:0];
                CFG_CENTER: center = data[11:0];
                CFG_ENABLE: enable = data[0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic [IN_W-1:0] tdata);
            longint err, dt, v, stp, target, nv, lim, prod, dac, turn;
            tick_result_t res;
            err = longint'($signed(tdata[15:0]));
            dt = longint'(tdata[27:16]);
            v = longint'(vel);
            stp = (longint'(accel) * dt + 512) >>> 10;
            lim = longint'(band);
            if (err > lim || err < -lim) begin
                slewing++;
                target = -(longint'(gain) * err);
                if (v * 64 > target) begin
                    nv = v - stp;
                    if (nv * 64 >= target) v = nv;
                    else held++;
                end else if (v * 64 < target) begin
                    nv = v + stp;
                    if (nv * 64 <= target) v = nv;
                    else held++;
                end
            end else begin
                in_band++;
                if (v < 0) begin
                    v = v + stp;
                    if (v > 0) v = 0;
                end else if (v > 0) begin
                    v = v - stp;
                    if (v < 0) v = 0;
                end
            end
            if (v > 16384) begin
                v = 16384;
                saturated++;
            end else if (v < -16384) begin
                v = -16384;
                saturated++;
            end
            vel = v[15:0];
            if (enable) begin
                prod = v * longint'(drive) + 8192;
                dac = longint'(center) + (prod >>> 14);
            end else begin
                dac = longint'(center);
                drive_off++;
            end
            if (dac < 0) dac = 0;
            if (dac > DAC_MAX) dac = DAC_MAX;
            turn = v * dt;
            angle = angle + turn[31:0];
            res.dac = dac[DAC_BITS-1:0];
            res.vel = vel;
            res.angle = angle;
            expected_q.push_back(res);
        endfunction

        function void check_tick(logic [OUT_W-1:0] tdata);
            tick_result_t exp_res, got;
            got.dac = tdata[DAC_BITS-1:0];
            got.vel = tdata[DAC_BITS +: 16];
            got.angle = tdata[DAC_BITS+16 +: 32];
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected, dac %0d velocity %0d angle %0d",
                         $time, got.dac, got.vel, got.angle);
                fail_count++;
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (got.dac !== exp_res.dac) begin
                $display("%0t: dac_code expected %0d got %0d", $time, exp_res.dac, got.dac);
                fail_count++;
            end
            if (got.vel !== exp_res.vel) begin
                $display("%0t: turn_velocity expected %0d got %0d",
                         $time, exp_res.vel, got.vel);
                fail_count++;
            end
            if (got.angle !== exp_res.angle) begin
                $display("%0t: table_angle expected %0d got %0d",
                         $time, $signed(exp_res.angle), $signed(got.angle));
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [CFG_DW-1:0]   i_cfg_data = '0;

    tick_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          settings_used = 0;
    int          heading = 0;
    logic [14:0] cur_band = 15'd357;

    turntable_rate_limited_velocity_loop_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_tick(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) sb.note_tick(s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // A requested hold keeps the receiver off until the hold counter runs out.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_tick(input logic signed [15:0] err, input logic [11:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, dt, err};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [16:0] accel, input logic [11:0] gain,
                                input logic [14:0] band, input logic [11:0] drive,
                                input logic [11:0] center, input logic enable);
        write_reg(CFG_ACCEL, accel);
        write_reg(CFG_GAIN, CFG_DW'(gain));
        write_reg(CFG_DBAND, CFG_DW'(band));
        write_reg(CFG_DRIVE, CFG_DW'(drive));
        write_reg(CFG_CENTER, CFG_DW'(center));
        write_reg(CFG_ENABLE, CFG_DW'(enable));
        i_cfg_valid <= 1'b0;
        cur_band = band;
        settings_used++;
    endtask

    // Two ticks in five follow a slowly drifting heading so the velocity settles on its target.
    task automatic gen_tick(output logic signed [15:0] err, output logic [11:0] dt);
        int roll, e;
        roll = $urandom_range(99);
        dt = 12'($urandom);
        if (roll < 25) begin
            e = int'($urandom_range(65535)) - 32768;
        end else if (roll < 65) begin
            if ($urandom_range(15) == 0) heading = int'($urandom_range(16000)) - 8000;
            else heading = heading + int'($urandom_range(400)) - 200;
            if (heading > 32767) heading = 32767;
            if (heading < -32768) heading = -32768;
            e = heading;
            dt = 12'($urandom_range(40, 1));
        end else if (roll < 80) begin
            e = int'($urandom_range(2 * int'(cur_band))) - int'(cur_band);
            dt = 12'($urandom_range(600));
        end else begin
            case ($urandom_range(5))
                0: e = int'(cur_band);
                1: e = -int'(cur_band);
                2: e = int'(cur_band) + 1;
                3: e = -int'(cur_band) - 1;
                4: e = 32767;
                default: e = -32768;
            endcase
            if ($urandom_range(1) == 1) dt = ($urandom_range(1) == 1) ? 12'd0 : 12'hFFF;
        end
        err = 16'(e);
    endtask

    initial begin : stimulus
        logic signed [15:0] err;
        logic [11:0]        dt;
        int                 idle_send[4];
        int                 idle_recv[4];
        idle_send = '{0, 88, 0, 21};
        idle_recv = '{0, 0, 88, 21};
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: deadband edges, exact reach, hold at and short of target,
        // decay to zero from both signs, saturation and zero elapsed time.
        send_tick(16'sd0, 12'd0);
        send_tick(16'sd357, 12'd100);
        send_tick(-16'sd357, 12'd100);
        send_tick(-16'sd400, 12'd100);
        send_tick(-16'sd400, 12'd10);
        send_tick(-16'sd500, 12'd50);
        send_tick(16'sd0, 12'd50);
        send_tick(-16'sd357, 12'd100);
        send_tick(16'sd1000, 12'd250);
        send_tick(-16'sd32768, 12'd4095);
        send_tick(16'sd358, 12'd0);
        send_tick(16'sd32767, 12'd4095);
        send_tick(16'sd0, 12'd100);
        send_tick(16'sd0, 12'd4095);
        send_tick(-16'sd32768, 12'd4095);
        send_tick(16'sd32767, 12'd1);
        send_tick(-16'sd358, 12'd4095);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_config(17'h1FFFF, 12'hFFF, 15'h7FFF, 12'hFFF, 12'hFFF, 1'b1);
                1: apply_config(17'd0, 12'd0, 15'd0, 12'd0, 12'd0, 1'b0);
                2: apply_config(17'h1FFFF, 12'hFFF, 15'd0, 12'hFFF, 12'd0, 1'b1);
                3: apply_config(17'd32768, 12'd512, 15'd357, 12'd1019, 12'd2048, 1'b1);
                default: apply_config(17'($urandom_range(40000, 1000)),
                                      12'($urandom), 15'($urandom_range(2000)),
                                      12'($urandom), 12'($urandom),
                                      $urandom_range(99) < 75);
            endcase
            send_idle_pct = idle_send[p % 4];
            recv_stall_pct = idle_recv[p % 4];
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                if (n == 50) hold_left = HOLD_CYCLES;
                if (n == 100) wait_drained();
                gen_tick(err, dt);
                send_tick(err, dt);
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Checked %0d results across %0d register settings and four idle patterns.",
                 sb.checked, settings_used);
        $display("Ticks: %0d slewing, %0d in deadband, %0d held short, %0d saturated, %0d disabled.",
                 sb.slewing, sb.in_band, sb.held, sb.saturated, sb.drive_off);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/trlvl_pkg.sv
hw/rtl/trlvl_ctrl.sv
hw/rtl/trlvl_dpath.sv
hw/rtl/turntable_rate_limited_velocity_loop_unit.sv
dv/tb_turntable_rate_limited_velocity_loop_unit.sv
